// File: rtl/rtsp_rhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTSP request header scanner package
// Shared codes, the per-request parse state and the method and protocol text.
// ----------------------------------------------------------------------------
package rtsp_rhs_pkg;

	localparam int NUM_METHODS = 10;

	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_WAIT  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_ABORT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_DONE    = 3'd1,
		ST_BLANK   = 3'd2,
		ST_CLOSED  = 3'd3,
		ST_TIMEOUT = 3'd4,
		ST_ABORTED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		END_NONE     = 3'd0,
		END_CRLFCRLF = 3'd1,
		END_LFCRLFCR = 3'd2,
		END_CRCR     = 3'd3,
		END_LFLF     = 3'd4
	} end_kind_t;

	localparam logic [1:0] TOK_METHOD = 2'd0;
	localparam logic [1:0] TOK_URL    = 2'd1;
	localparam logic [1:0] TOK_PROTO  = 2'd2;
	localparam logic [1:0] TOK_PAST   = 2'd3;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam logic [3:0] PROTO_LEN = 4'd8;
	localparam logic [3:0] POS_MAX   = 4'd15;
	localparam logic [63:0] PROTO_TEXT = "RTSP/1.0";

	localparam logic [103:0] METHOD_TEXT [NUM_METHODS] = '{
		104'("DESCRIBE"), 104'({"GET_", "PARAMETER"}), 104'("OPTIONS"), 104'("PAUSE"),
		104'("PLAY"), 104'("PING"), 104'("REDIRECT"), 104'("SETUP"),
		104'({"SET_", "PARAMETER"}), 104'("TEARDOWN")
	};
	localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
		4'd8, 4'd13, 4'd7, 4'd5, 4'd4, 4'd4, 4'd8, 4'd5, 4'd13, 4'd8
	};

	typedef struct packed {
		logic                   in_first_line;
		logic [1:0]             token_index;
		logic [3:0]             token_position;
		logic [NUM_METHODS-1:0] method_candidates;
		logic [3:0]             method_found;
		logic                   protocol_match;
	} line_state_t;

	localparam line_state_t LINE_RESET = '{
		in_first_line:     1'b1,
		token_index:       TOK_METHOD,
		token_position:    4'd0,
		method_candidates: '1,
		method_found:      4'd0,
		protocol_match:    1'b0
	};

	function automatic logic is_eol(input logic [7:0] b);
		return (b == CH_CR) || (b == CH_LF);
	endfunction

	// Character at a position of a method name; valid only below its length.
	function automatic logic [7:0] method_char(input logic [3:0] idx,
			input logic [3:0] pos);
		logic [3:0] back;
		logic [6:0] bit_lo;
		back   = METHOD_LEN[idx] - 4'd1 - pos;
		bit_lo = {back, 3'b000};
		return METHOD_TEXT[idx][bit_lo +: 8];
	endfunction

	function automatic logic [7:0] proto_char(input logic [2:0] pos);
		logic [5:0] bit_lo;
		bit_lo = {~pos, 3'b000};
		return PROTO_TEXT[bit_lo +: 8];
	endfunction

endpackage

// File: rtl/rtsp_request_header_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTSP request header scanner
// Scans a request byte stream for the header end and parses the request line.
//
// Channel   Direction  Accepted when            Carries
// s_*       in         s_tvalid && s_tready     command, data byte
// m_*       out        m_tvalid && m_tready     one result per input item
// cfg_*     in         cfg_valid && cfg_ready   wait limit
//
// Each item is held in the input register and then moves to the result
// register, which offers its result. One item is taken per cycle while
// m_tready does not stall a full result register; the per-byte compare
// logic sets the clock. A stall on m_tready holds the result and stops
// the input register only when that register is full. Reset clears the
// request state and sets the wait limit to 120. cfg_ready is always high.
// ----------------------------------------------------------------------------
module rtsp_request_header_scanner_top
	import rtsp_rhs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] end_kind, [6:3] method_code,
	                               // [7] protocol_ok, [23:8] header_length
	output logic [2:0]  m_tuser,   // [2:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	status_t     status_s2;
	end_kind_t   kind_s2;
	logic [3:0]  method_s2;
	logic        proto_s2;
	logic [15:0] length_s2;

	logic [7:0]  max_wait_q;
	logic [31:0] recent_q;
	logic [15:0] count_q;
	logic [7:0]  wait_q;
	line_state_t line_q;

	logic        advance;
	logic        fire;
	logic [31:0] recent_shift;
	logic [15:0] count_inc;
	logic [8:0]  wait_inc;
	line_state_t line_parsed;
	logic        blank;
	end_kind_t   end_kind;

	status_t     status_nx;
	end_kind_t   kind_nx;
	logic [3:0]  method_nx;
	logic        proto_nx;
	logic [15:0] length_nx;
	logic [31:0] recent_nx;
	logic [15:0] count_nx;
	logic [7:0]  wait_nx;
	line_state_t line_nx;

	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	assign recent_shift = {recent_q[23:0], byte_s1};
	assign count_inc    = (count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;
	assign wait_inc     = {1'b0, wait_q} + 9'd1;

	rtsp_rhs_line_parse u_line (
		.cur       (line_q),
		.data_byte (byte_s1),
		.nxt       (line_parsed)
	);

	rtsp_rhs_end_detect u_end (
		.recent (recent_shift),
		.count  (count_inc),
		.blank  (blank),
		.kind   (end_kind)
	);

	always_comb begin
		status_nx = ST_BUSY;
		kind_nx   = END_NONE;
		method_nx = 4'd0;
		proto_nx  = 1'b0;
		length_nx = count_q;
		recent_nx = recent_q;
		count_nx  = count_q;
		wait_nx   = wait_q;
		line_nx   = line_q;
		case (cmd_s1)
			CMD_DATA: begin
				recent_nx = recent_shift;
				count_nx  = count_inc;
				length_nx = count_inc;
				wait_nx   = 8'd0;
				line_nx   = line_parsed;
				if (is_eol(byte_s1)) begin
					if (blank) begin
						status_nx = ST_BLANK;
					end else if (end_kind != END_NONE) begin
						status_nx = ST_DONE;
						kind_nx   = end_kind;
						method_nx = line_parsed.method_found;
						proto_nx  = line_parsed.protocol_match;
					end
				end
			end
			CMD_WAIT: begin
				if (wait_inc > {1'b0, max_wait_q}) begin
					status_nx = ST_TIMEOUT;
				end else begin
					wait_nx = wait_inc[7:0];
				end
			end
			CMD_CLOSE: begin
				status_nx = ST_CLOSED;
			end
			default: begin
				status_nx = ST_ABORTED;
			end
		endcase
		if (status_nx != ST_BUSY) begin
			recent_nx = 32'd0;
			count_nx  = 16'd0;
			wait_nx   = 8'd0;
			line_nx   = LINE_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			max_wait_q <= 8'd120;
			recent_q   <= 32'd0;
			count_q    <= 16'd0;
			wait_q     <= 8'd0;
			line_q     <= LINE_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (cfg_valid && cfg_ready) begin
				max_wait_q <= cfg_data;
			end
			if (fire) begin
				recent_q <= recent_nx;
				count_q  <= count_nx;
				wait_q   <= wait_nx;
				line_q   <= line_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= cmd_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
		if (fire) begin
			status_s2 <= status_nx;
			kind_s2   <= kind_nx;
			method_s2 <= method_nx;
			proto_s2  <= proto_nx;
			length_s2 <= length_nx;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {length_s2, proto_s2, method_s2, kind_s2};

endmodule

// File: rtl/rtsp_rhs_line_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTSP request line parser
// Advances the first-line token state by one received byte.
// ----------------------------------------------------------------------------
module rtsp_rhs_line_parse
	import rtsp_rhs_pkg::*;
(
	input  line_state_t cur,
	input  logic [7:0]  data_byte,
	output line_state_t nxt
);

	logic [7:0] upper;
	logic [3:0] found;

	assign upper = (data_byte >= 8'h61 && data_byte <= 8'h7A) ? data_byte - 8'h20 : data_byte;

	always_comb begin
		found = 4'd0;
		for (int i = NUM_METHODS - 1; i >= 0; i--) begin
			if (cur.method_candidates[i] && METHOD_LEN[i] == cur.token_position) begin
				found = 4'(i + 1);
			end
		end
	end

	always_comb begin
		nxt = cur;
		if (cur.in_first_line) begin
			if (is_eol(data_byte)) begin
				if (cur.token_index == TOK_METHOD) begin
					nxt.method_found = found;
				end else if (cur.token_index == TOK_PROTO &&
						cur.token_position != PROTO_LEN) begin
					nxt.protocol_match = 1'b0;
				end
				nxt.in_first_line = 1'b0;
			end else if (data_byte == CH_SP) begin
				case (cur.token_index)
					TOK_METHOD: begin
						nxt.method_found = found;
						nxt.token_index  = TOK_URL;
					end
					TOK_URL: begin
						nxt.token_index    = TOK_PROTO;
						nxt.protocol_match = 1'b1;
					end
					TOK_PROTO: begin
						if (cur.token_position != PROTO_LEN) begin
							nxt.protocol_match = 1'b0;
						end
						nxt.token_index = TOK_PAST;
					end
					default: begin
						nxt.token_index = cur.token_index;
					end
				endcase
				nxt.token_position = 4'd0;
			end else begin
				if (cur.token_index == TOK_METHOD) begin
					for (int i = 0; i < NUM_METHODS; i++) begin
						if (cur.token_position >= METHOD_LEN[i] ||
								method_char(4'(i), cur.token_position) != upper) begin
							nxt.method_candidates[i] = 1'b0;
						end
					end
				end else if (cur.token_index == TOK_PROTO) begin
					if (cur.token_position >= PROTO_LEN ||
							proto_char(cur.token_position[2:0]) != data_byte) begin
						nxt.protocol_match = 1'b0;
					end
				end
				if (cur.token_position != POS_MAX) begin
					nxt.token_position = cur.token_position + 4'd1;
				end
			end
		end
	end

endmodule

// File: rtl/rtsp_rhs_end_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTSP header end detector
// Classifies the byte history after a line break as blank, terminator or none.
// ----------------------------------------------------------------------------
module rtsp_rhs_end_detect
	import rtsp_rhs_pkg::*;
(
	input  logic [31:0] recent,
	input  logic [15:0] count,
	output logic        blank,
	output end_kind_t   kind
);

	always_comb begin
		blank = 1'b0;
		kind  = END_NONE;
		if (count <= 16'd1) begin
			blank = 1'b1;
		end else if (count == 16'd2 || count == 16'd3) begin
			blank = is_eol(recent[15:8]) && is_eol(recent[7:0]);
		end else if (recent == {CH_CR, CH_LF, CH_CR, CH_LF}) begin
			kind = END_CRLFCRLF;
		end else if (recent == {CH_LF, CH_CR, CH_LF, CH_CR}) begin
			kind = END_LFCRLFCR;
		end else if (recent[15:0] == {CH_CR, CH_CR}) begin
			kind = END_CRCR;
		end else if (recent[15:0] == {CH_LF, CH_LF}) begin
			kind = END_LFLF;
		end
	end

endmodule

// File: rtl/rtsp_rhs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTSP request header scanner checker
// Port-level properties of the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rtsp_rhs_checker
	import rtsp_rhs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result item changed while stalled.");

	a_detail_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_DONE |-> m_tdata[7:0] == 8'd0)
		else $error("End kind, method or protocol flag set without header done.");

	a_done_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_DONE |-> m_tdata[2:0] != END_NONE &&
			m_tdata[23:8] >= 16'd4)
		else $error("Header done without a terminator or with too few bytes.");

	a_blank_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_BLANK |-> m_tdata[23:8] <= 16'd3 &&
			m_tdata[23:8] != 16'd0)
		else $error("Blank request reported with an unexpected length.");

endmodule

bind rtsp_request_header_scanner_top rtsp_rhs_checker u_rtsp_rhs_checker (.*);
